>>> hdl/wsmc_pkg.sv
package wsmc_pkg;

  localparam int SampleW = 16;
  localparam int IdW     = 4;
  localparam int ModeW   = 2;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_DIST_SPREAD  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ANGLE_SPREAD = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FAR_DIST     = 2'd2;

  localparam logic [SampleW-1:0] DIST_SPREAD_RST  = 16'd100;
  localparam logic [SampleW-1:0] ANGLE_SPREAD_RST = 16'd20480;
  localparam logic [SampleW-1:0] FAR_DIST_RST     = 16'd5000;

  localparam logic [ModeW-1:0] MODE_NEAR = 2'd0;
  localparam logic [ModeW-1:0] MODE_FAR  = 2'd1;
  localparam logic [ModeW-1:0] MODE_SPIN = 2'd2;

  localparam logic [1:0] SEL_DIST = 2'd0;
  localparam logic [1:0] SEL_A    = 2'd1;
  localparam logic [1:0] SEL_B    = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACC,
    ST_DRAIN,
    ST_MUL,
    ST_SUB,
    ST_DIV,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_STORE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic mul;
    logic sub;
    logic div_step;
    logic root_load;
    logic root_step;
    logic store;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_new;
    logic issue_last;
    logic pipe_empty;
    logic div_last;
    logic root_last;
    logic sel_last;
    logic out_free;
  } status_t;

endpackage

>>> hdl/wsmc_ctrl.sv
module wsmc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wsmc_pkg::status_t status,
  output wsmc_pkg::cmd_t    cmd
);
  import wsmc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: state_next = status.is_new ? ST_FINISH : ST_ACC;
      ST_ACC: begin
        cmd.issue = 1'b1;
        if (status.issue_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: if (status.pipe_empty) state_next = ST_MUL;
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = ST_ROOT_LOAD;
      end
      ST_ROOT_LOAD: begin
        cmd.root_load = 1'b1;
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) state_next = ST_STORE;
      end
      ST_STORE: begin
        cmd.store  = 1'b1;
        state_next = status.sel_last ? ST_FINISH : ST_MUL;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_CHECK)
    else $error("load did not move to check");
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over a waiting word");
  a_new_skips: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && status.is_new) |=> state == ST_FINISH)
    else $error("id change ran statistics");

endmodule

>>> hdl/wsmc_datapath.sv
module wsmc_datapath #(
  parameter int WINDOW = 30
) (
  input  logic                            clk,
  input  logic                            rst,
  input  wsmc_pkg::cmd_t                  cmd,
  output wsmc_pkg::status_t               status,
  input  logic                            cfg_we,
  input  logic [wsmc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [wsmc_pkg::SampleW-1:0]    cfg_wdata,
  input  logic [wsmc_pkg::IdW-1:0]        in_id,
  input  logic [wsmc_pkg::SampleW-1:0]    in_dist,
  input  logic signed [wsmc_pkg::SampleW-1:0] in_a,
  input  logic signed [wsmc_pkg::SampleW-1:0] in_b,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [wsmc_pkg::ModeW-1:0]      out_mode
);
  import wsmc_pkg::*;

  localparam int DEPTH = WINDOW + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = SampleW + 1 + CW;
  localparam int QW    = 2 * SampleW + CW;
  localparam int DW    = 2 * SampleW + 2 * CW;
  localparam int MW    = 2 * CW;
  localparam int RW    = DW / 2;
  localparam int KW    = $clog2(DW);
  localparam int EW    = 3 * SampleW;

  // configuration
  logic [SampleW-1:0] dist_limit, angle_limit, far_dist;
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_limit  <= DIST_SPREAD_RST;
      angle_limit <= ANGLE_SPREAD_RST;
      far_dist    <= FAR_DIST_RST;
    end else if (cfg_we) begin
      priority case (cfg_index)
        REG_DIST_SPREAD:  dist_limit  <= cfg_wdata;
        REG_ANGLE_SPREAD: angle_limit <= cfg_wdata;
        REG_FAR_DIST:     far_dist    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // window bookkeeping
  logic [AW-1:0]  head, base;
  logic [CW-1:0]  fill, n;
  logic [IdW-1:0] prev_id;
  logic           have_prev, is_new, far_bit;

  logic           new_item;
  logic [CW:0]    pos_sum, pos_wrap, fill_inc;
  logic [AW-1:0]  wr_addr;
  logic [AW:0]    head_inc;

  assign new_item = !have_prev || (in_id != prev_id);
  assign pos_sum  = (CW+1)'(head) + (CW+1)'(fill);
  assign pos_wrap = (pos_sum >= (CW+1)'(DEPTH)) ? pos_sum - (CW+1)'(DEPTH) : pos_sum;
  assign wr_addr  = new_item ? '0 : AW'(pos_wrap);
  assign fill_inc = (CW+1)'(fill) + 1'b1;
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : (AW+1)'(head) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      fill      <= '0;
      prev_id   <= '0;
      have_prev <= 1'b0;
    end else if (cmd.load) begin
      prev_id   <= in_id;
      have_prev <= 1'b1;
      if (new_item) begin
        head <= '0;
        fill <= CW'(1);
      end else if (fill_inc == (CW+1)'(DEPTH)) begin
        // full: the stats see every entry, then the oldest drops out
        head <= AW'(head_inc);
        fill <= CW'(WINDOW);
      end else begin
        fill <= CW'(fill_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_new  <= new_item;
      far_bit <= in_dist > far_dist;
      base    <= head;
      n       <= CW'(fill_inc);
    end
  end

  // sample store
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_word;
  logic [CW-1:0] idx;
  logic [CW:0]   rd_sum, rd_wrap;

  assign rd_sum  = (CW+1)'(base) + (CW+1)'(idx);
  assign rd_wrap = (rd_sum >= (CW+1)'(DEPTH)) ? rd_sum - (CW+1)'(DEPTH) : rd_sum;

  always_ff @(posedge clk) begin
    if (cmd.load) mem[wr_addr] <= {in_b, in_a, in_dist};
    rd_word <= mem[AW'(rd_wrap)];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) idx <= '0;
    else if (cmd.issue) idx <= idx + 1'b1;
  end

  // accumulate: read, square, sum
  logic v1, v2;
  logic signed [SampleW:0]   xd, xa, xb;
  logic signed [2*SampleW+1:0] pd, pa, pb;
  logic [2*SampleW-1:0]      sqd, sqa, sqb;
  logic signed [SampleW:0]   rd_d, rd_a, rd_b;
  logic signed [SW-1:0]      sum_d, sum_a, sum_b;
  logic [QW-1:0]             ssq_d, ssq_a, ssq_b;

  assign xd = {1'b0, rd_word[SampleW-1:0]};
  assign xa = {rd_word[2*SampleW-1], rd_word[2*SampleW-1:SampleW]};
  assign xb = {rd_word[3*SampleW-1], rd_word[3*SampleW-1:2*SampleW]};
  assign pd = xd * xd;
  assign pa = xa * xa;
  assign pb = xb * xb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      rd_d <= xd;
      rd_a <= xa;
      rd_b <= xb;
      sqd  <= pd[2*SampleW-1:0];
      sqa  <= pa[2*SampleW-1:0];
      sqb  <= pb[2*SampleW-1:0];
    end
    if (cmd.load) begin
      sum_d <= '0;
      sum_a <= '0;
      sum_b <= '0;
      ssq_d <= '0;
      ssq_a <= '0;
      ssq_b <= '0;
    end else if (v2) begin
      sum_d <= sum_d + SW'(rd_d);
      sum_a <= sum_a + SW'(rd_a);
      sum_b <= sum_b + SW'(rd_b);
      ssq_d <= ssq_d + QW'(sqd);
      ssq_a <= ssq_a + QW'(sqa);
      ssq_b <= ssq_b + QW'(sqb);
    end
  end

  // spread: D = n*sumsq - sum^2, divide by n(n-1), then square root
  logic [1:0]          sel;
  logic signed [SW-1:0] sum_sel;
  logic [QW-1:0]       ssq_sel;
  logic [SW-1:0]       mag;
  logic [2*SW-1:0]     magsq;
  logic [DW-1:0]       nsq, p1, p2;
  logic [MW-1:0]       m_full, mdiv;

  always_comb begin
    unique case (sel)
      SEL_A: begin
        sum_sel = sum_a;
        ssq_sel = ssq_a;
      end
      SEL_B: begin
        sum_sel = sum_b;
        ssq_sel = ssq_b;
      end
      default: begin
        sum_sel = sum_d;
        ssq_sel = ssq_d;
      end
    endcase
  end

  assign mag    = sum_sel[SW-1] ? SW'(-sum_sel) : SW'(sum_sel);
  assign magsq  = mag * mag;
  assign nsq    = n * ssq_sel;
  assign m_full = n * (n - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p1   <= nsq;
      p2   <= DW'(magsq);
      mdiv <= m_full;
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [DW-1:0] quo;
  logic [MW-1:0] rem;
  logic [MW:0]   dtrial;
  logic [KW-1:0] step;

  assign dtrial = {rem, quo[DW-1]};

  always_ff @(posedge clk) begin
    if (cmd.sub) begin
      quo <= p1 - p2;
      rem <= '0;
    end else if (cmd.div_step) begin
      if (dtrial >= (MW+1)'(mdiv)) begin
        rem <= MW'(dtrial - (MW+1)'(mdiv));
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= MW'(dtrial);
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  // integer square root, two radicand bits a cycle
  logic [DW-1:0] rad;
  logic [RW-1:0] root;
  logic [RW+1:0] rrem, rshift, rtrial;

  assign rshift = {rrem[RW-1:0], rad[DW-1:DW-2]};
  assign rtrial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.root_load) begin
      rad  <= quo;
      root <= '0;
      rrem <= '0;
    end else if (cmd.root_step) begin
      rad <= {rad[DW-3:0], 2'b00};
      if (rshift >= rtrial) begin
        rrem <= rshift - rtrial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rrem <= rshift;
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sub || cmd.root_load) step <= '0;
    else if (cmd.div_step || cmd.root_step) step <= step + 1'b1;
  end

  logic [RW-1:0] s_d, s_a, s_b;
  always_ff @(posedge clk) begin
    if (cmd.load) sel <= SEL_DIST;
    else if (cmd.store) sel <= sel + 1'b1;
    if (cmd.store) begin
      unique case (sel)
        SEL_A:   s_a <= root;
        SEL_B:   s_b <= root;
        default: s_d <= root;
      endcase
    end
  end

  // result
  logic [ModeW-1:0] mode;
  logic             spin;
  assign spin = (s_d < RW'(dist_limit)) &&
                ((RW+1)'(s_a) + (RW+1)'(s_b) > (RW+1)'(angle_limit));
  assign mode = (!is_new && spin) ? MODE_SPIN : (far_bit ? MODE_FAR : MODE_NEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_mode <= mode;
  end

  assign status.is_new     = is_new;
  assign status.issue_last = (idx == n - 1'b1);
  assign status.pipe_empty = !v1 && !v2;
  assign status.div_last   = (step == KW'(DW - 1));
  assign status.root_last  = (step == KW'(RW - 1));
  assign status.sel_last   = (sel == SEL_B);
  assign status.out_free   = !out_valid || out_ready;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(WINDOW))
    else $error("window fill beyond its length");
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head < AW'(DEPTH))
    else $error("window head out of range");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> rem < mdiv)
    else $error("divider remainder not below divisor");

endmodule

>>> hdl/window_spread_mode_classifier.sv
// channel   direction  word
// s_axis    in         target_id, distance_mm, angle_a, angle_b
// m_axis    out        track_mode
// cfg       in         register write, no read-back
//
// A new target id skips the statistics and goes straight to a result. A
// repeated id reads the n window entries once, then runs three spreads
// one after another through a shared bit-serial divider and square root
// unit, whose width is DW = 32 + 2 * clog2(WINDOW + 2).
// Synchronous reset clears control and loads the register defaults.
// A waiting result does not block the next word; only a second result does.
module window_spread_mode_classifier #(
  parameter int WINDOW = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // target_id, distance_mm, angle_a, angle_b, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // track_mode, pad
  input  logic        cfg_we,
  input  logic [wsmc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [wsmc_pkg::SampleW-1:0] cfg_wdata
);
  import wsmc_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [ModeW-1:0] mode;

  wsmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  wsmc_datapath #(.WINDOW(WINDOW)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_id     (s_axis_tdata[3:0]),
    .in_dist   (s_axis_tdata[19:4]),
    .in_a      (s_axis_tdata[35:20]),
    .in_b      (s_axis_tdata[51:36]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_mode  (mode)
  );

  assign m_axis_tdata = {{(8-ModeW){1'b0}}, mode};

endmodule
